[src/rci_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rci_pkg
// Shared widths, register indexes and pipeline sideband types for the
// ray/cylinder intersection unit.
// ----------------------------------------------------------------------------
package rci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;          // input and register fields
    localparam int OFS_W     = IN_W + 1;    // origin minus centre
    localparam int RAD_W     = 31;
    localparam int DIST_W    = 31;
    localparam int AW        = 64;          // A = dx^2 + dz^2
    localparam int HW        = 66;          // H = ox*dx + oz*dz
    localparam int CW        = 67;          // C = ox^2 + oz^2 - r^2
    localparam int WW        = 136;         // discriminant working width
    localparam int DW        = 130;         // discriminant as seen by the root
    localparam int SW        = DW / 2;      // root width
    localparam int RW        = SW + 2;      // root remainder width
    localparam int NW        = 68;          // signed numerator width
    localparam int ADDR_W    = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Z = 2'd1,
        REG_RADIUS   = 2'd2
    } t_reg_idx;

    typedef logic signed [WW-1:0] t_wide;

    // Travels alongside the discriminant through the square root stages.
    typedef struct packed {
        logic                 v;
        logic                 miss;
        logic signed [HW-1:0] h;
        logic [AW-1:0]        a;
    } t_side;

    // Travels alongside the partial remainder through the divider stages.
    typedef struct packed {
        logic              v;
        logic              hit;
        logic              sat;
        logic [AW-1:0]     a;
        logic [DIST_W-1:0] low;
        logic [DIST_W-1:0] q;
    } t_div;

endpackage
`default_nettype wire

[src/rci_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rci_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rci_sqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [rci_pkg::DW-1:0] i_rad,
    input  wire rci_pkg::t_side        i_side,
    output logic [rci_pkg::SW-1:0]     o_root,
    output rci_pkg::t_side             o_side
);
    import rci_pkg::*;

    logic [RW-1:0] r_rem  [SW];
    logic [SW-1:0] r_root [SW];
    logic [DW-1:0] r_rad  [SW];
    t_side         r_side [SW];

    for (genvar k = 0; k < SW; k++) begin : g_step
        logic [RW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [DW-1:0] rad_in;
        t_side         side_in;
        logic [RW-1:0] n_part;
        logic [RW-1:0] n_trial;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign n_part  = {rem_in[RW-3:0], rad_in[DW-1:DW-2]};
        assign n_trial = RW'({root_in[SW-2:0], 2'b01});
        assign n_ge    = (n_part >= n_trial);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_ge ? (n_part - n_trial) : n_part;
            r_root[k] <= {root_in[SW-2:0], n_ge};
            r_rad[k]  <= {rad_in[DW-3:0], 2'b00};
            if (!i_rst_n) begin
                r_side[k].v <= 1'b0;
            end else begin
                r_side[k] <= side_in;
            end
        end
    end

    assign o_root = r_root[SW-1];
    assign o_side = r_side[SW-1];

endmodule
`default_nettype wire

[src/rci_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rci_div
// Pipelined restoring divider giving the distance quotient, one bit per stage.
// ----------------------------------------------------------------------------
module rci_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [rci_pkg::AW-1:0] i_rem,
    input  wire rci_pkg::t_div         i_div,
    output rci_pkg::t_div              o_div
);
    import rci_pkg::*;

    logic [AW-1:0] r_rem [DIST_W];
    t_div          r_div [DIST_W];

    for (genvar k = 0; k < DIST_W; k++) begin : g_step
        logic [AW-1:0] rem_in;
        t_div          div_in;
        logic [AW:0]   n_part;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign rem_in = i_rem;
            assign div_in = i_div;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign div_in = r_div[k-1];
        end

        assign n_part = {rem_in, div_in.low[DIST_W-1]};
        assign n_ge   = (n_part >= {1'b0, div_in.a});

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? AW'(n_part - {1'b0, div_in.a}) : AW'(n_part);
            if (!i_rst_n) begin
                r_div[k].v <= 1'b0;
            end else begin
                r_div[k].v   <= div_in.v;
                r_div[k].hit <= div_in.hit;
                r_div[k].sat <= div_in.sat;
                r_div[k].a   <= div_in.a;
                r_div[k].low <= {div_in.low[DIST_W-2:0], 1'b0};
                r_div[k].q   <= {div_in.q[DIST_W-2:0], n_ge};
            end
        end
    end

    assign o_div = r_div[DIST_W-1];

endmodule
`default_nettype wire

[src/ray_cylinder_intersection_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_cylinder_intersection_unit
// Intersects a stream of rays with an infinite y-axis cylinder, Q16.16.
//
//   channel   direction  handshake                      beat
//   ray       in         start (busy is never raised)   origin x/z, dir x/z
//   result    out        o_done strobe, one cycle       hit, distance
//   config    in         APB write, pready always high  centre x/z, radius
//
// One ray is taken every cycle. The depth is set by the 65-stage square
// root and the 31-stage divider, one bit per stage. Reset clears the valid
// bits and loads the registers with centre 0 and radius 1.0. Results cannot
// be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module ray_cylinder_intersection_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [rci_pkg::IN_W-1:0] i_origin_x,
    input  wire logic signed [rci_pkg::IN_W-1:0] i_origin_z,
    input  wire logic signed [rci_pkg::IN_W-1:0] i_dir_x,
    input  wire logic signed [rci_pkg::IN_W-1:0] i_dir_z,
    output logic                                 o_done,
    output logic                                 o_hit,
    output logic [rci_pkg::DIST_W-1:0]           o_distance,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rci_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rci_pkg::*;

    // Configuration registers
    logic signed [IN_W-1:0] r_center_x;
    logic signed [IN_W-1:0] r_center_z;
    logic [RAD_W-1:0]       r_radius;
    t_reg_idx               reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_z <= '0;
            r_radius   <= RADIUS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_X: r_center_x <= pwdata;
                REG_CENTER_Z: r_center_z <= pwdata;
                REG_RADIUS:   r_radius   <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = r_center_x;
            REG_CENTER_Z: prdata = r_center_z;
            REG_RADIUS:   prdata = {1'b0, r_radius};
            default:      prdata = '0;
        endcase
    end

    // Stage 1: origin relative to the axis
    logic                    r1_v;
    logic signed [OFS_W-1:0] r1_ox, r1_oz;
    logic signed [IN_W-1:0]  r1_dx, r1_dz;

    always_ff @(posedge i_clk) begin
        r1_ox <= OFS_W'(i_origin_x) - OFS_W'(r_center_x);
        r1_oz <= OFS_W'(i_origin_z) - OFS_W'(r_center_z);
        r1_dx <= i_dir_x;
        r1_dz <= i_dir_z;
        r1_v  <= i_rst_n & start & ~busy;
    end

    // Stage 2: squares and cross products
    logic                 r2_v;
    logic signed [63:0]   r2_dxx, r2_dzz;
    logic signed [64:0]   r2_oxdx, r2_ozdz;
    logic signed [65:0]   r2_oxx, r2_ozz;
    logic [2*RAD_W-1:0]   r2_rr;

    always_ff @(posedge i_clk) begin
        r2_dxx  <= r1_dx * r1_dx;
        r2_dzz  <= r1_dz * r1_dz;
        r2_oxdx <= r1_ox * r1_dx;
        r2_ozdz <= r1_oz * r1_dz;
        r2_oxx  <= r1_ox * r1_ox;
        r2_ozz  <= r1_oz * r1_oz;
        r2_rr   <= r_radius * r_radius;
        r2_v    <= i_rst_n & r1_v;
    end

    // Stage 3: quadratic coefficients
    logic                 r3_v;
    logic [AW-1:0]        r3_a;
    logic signed [HW-1:0] r3_h;
    logic signed [CW-1:0] r3_c;

    always_ff @(posedge i_clk) begin
        r3_a <= $unsigned(r2_dxx) + $unsigned(r2_dzz);
        r3_h <= HW'(r2_oxdx) + HW'(r2_ozdz);
        r3_c <= CW'(r2_oxx) + CW'(r2_ozz) - CW'(r2_rr);
        r3_v <= i_rst_n & r2_v;
    end

    // Stage 4: partial products of H^2 and A*C, each under 34 by 34 bits
    logic signed [32:0] h_hi, c_hi;
    logic [32:0]        h_lo;
    logic [31:0]        a_hi, a_lo;
    logic [33:0]        c_lo;

    assign h_hi = $signed(r3_h[65:33]);
    assign h_lo = r3_h[32:0];
    assign a_hi = r3_a[63:32];
    assign a_lo = r3_a[31:0];
    assign c_hi = $signed(r3_c[66:34]);
    assign c_lo = r3_c[33:0];

    t_side              r4_side;
    logic signed [65:0] r4_phh, r4_qhh, r4_qlh;
    logic signed [66:0] r4_phx;
    logic [65:0]        r4_pll, r4_qhl, r4_qll;

    always_ff @(posedge i_clk) begin
        r4_phh <= h_hi * h_hi;
        r4_phx <= h_hi * $signed({1'b0, h_lo});
        r4_pll <= h_lo * h_lo;
        r4_qhh <= $signed({1'b0, a_hi}) * c_hi;
        r4_qhl <= a_hi * c_lo;
        r4_qlh <= $signed({1'b0, a_lo}) * c_hi;
        r4_qll <= a_lo * c_lo;
        if (!i_rst_n) begin
            r4_side.v <= 1'b0;
        end else begin
            r4_side.v    <= r3_v;
            r4_side.miss <= (r3_a == '0);
            r4_side.h    <= r3_h;
            r4_side.a    <= r3_a;
        end
    end

    // Stage 5: first level of the partial product sums
    t_side r5_side;
    t_wide r5_h2a, r5_h2b, r5_aca, r5_acb;

    always_ff @(posedge i_clk) begin
        r5_h2a <= (t_wide'(r4_phh) <<< 66) + t_wide'(r4_pll);
        r5_h2b <= t_wide'(r4_phx) <<< 34;
        r5_aca <= (t_wide'(r4_qhh) <<< 66) + t_wide'(r4_qll);
        r5_acb <= (t_wide'(r4_qhl) <<< 32) + (t_wide'(r4_qlh) <<< 34);
        if (!i_rst_n) begin
            r5_side.v <= 1'b0;
        end else begin
            r5_side <= r4_side;
        end
    end

    // Stage 6: H^2 and A*C
    t_side r6_side;
    t_wide r6_h2, r6_ac;

    always_ff @(posedge i_clk) begin
        r6_h2 <= r5_h2a + r5_h2b;
        r6_ac <= r5_aca + r5_acb;
        if (!i_rst_n) begin
            r6_side.v <= 1'b0;
        end else begin
            r6_side <= r5_side;
        end
    end

    // Stage 7: discriminant; a negative one is a miss
    t_side         r7_side;
    t_wide         n_disc;
    logic [DW-1:0] r7_disc;

    assign n_disc = r6_h2 - r6_ac;

    always_ff @(posedge i_clk) begin
        r7_disc <= n_disc[DW-1:0];
        if (!i_rst_n) begin
            r7_side.v <= 1'b0;
        end else begin
            r7_side.v    <= r6_side.v;
            r7_side.miss <= r6_side.miss | n_disc[WW-1];
            r7_side.h    <= r6_side.h;
            r7_side.a    <= r6_side.a;
        end
    end

    logic [SW-1:0] sq_root;
    t_side         sq_side;

    rci_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   (r7_disc),
        .i_side  (r7_side),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 8: pick the nearer positive root numerator
    logic signed [NW-1:0] mh, n0, n1;
    logic                 pos0, pos1;

    assign mh   = -NW'(sq_side.h);
    assign n0   = mh - $signed(NW'(sq_root));
    assign n1   = mh + $signed(NW'(sq_root));
    assign pos0 = ~n0[NW-1] & (n0 != '0);
    assign pos1 = ~n1[NW-1] & (n1 != '0);

    logic            r8_v, r8_miss;
    logic [NW-2:0]   r8_num;
    logic [AW-1:0]   r8_a;

    always_ff @(posedge i_clk) begin
        r8_num  <= pos0 ? n0[NW-2:0] : n1[NW-2:0];
        r8_a    <= sq_side.a;
        r8_miss <= sq_side.miss | ~(pos0 | pos1);
        r8_v    <= i_rst_n & sq_side.v;
    end

    // Stage 9: saturation test and divider set-up
    localparam int XW = NW - 1 + FRAC_BITS;
    logic [XW-1:0] num_x;
    logic [AW-1:0] r9_rem;
    t_div          r9_div;

    assign num_x = {r8_num, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        // When not saturated the quotient fits in the distance width, so the
        // bits above it are already smaller than A.
        r9_rem <= AW'(num_x >> DIST_W);
        if (!i_rst_n) begin
            r9_div.v <= 1'b0;
        end else begin
            r9_div.v   <= r8_v;
            r9_div.hit <= ~r8_miss;
            r9_div.sat <= (r8_num >= {r8_a, {(DIST_W - FRAC_BITS){1'b0}}});
            r9_div.a   <= r8_a;
            r9_div.low <= num_x[DIST_W-1:0];
            r9_div.q   <= '0;
        end
    end

    t_div dv_out;

    rci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rem   (r9_rem),
        .i_div   (r9_div),
        .o_div   (dv_out)
    );

    // Output register
    logic              r_done, r_hit;
    logic [DIST_W-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_out.v;
        end
        r_hit <= dv_out.hit;
        if (!dv_out.hit) begin
            r_dist <= '0;
        end else if (dv_out.sat) begin
            r_dist <= DIST_MAX;
        end else begin
            r_dist <= dv_out.q;
        end
    end

    assign o_done     = r_done;
    assign o_hit      = r_hit;
    assign o_distance = r_dist;

endmodule
`default_nettype wire
